// File: hw/rtl/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
`default_nettype none
package gsa_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int GEN_BITS   = 16;
  localparam int IDX_W      = $clog2(SLOT_COUNT);
  localparam int CNT_W      = IDX_W + 1;

  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_TABLE_FULL  = 2'd1;
  localparam logic [1:0] ST_NEVER_ALLOC = 2'd2;
  localparam logic [1:0] ST_STACK_FULL  = 2'd3;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] slot_index;
  } gsa_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]    handle_index;
    logic [GEN_BITS-1:0] handle_generation;
    logic [1:0]          status;
  } gsa_out_t;

  typedef struct packed {
    logic             is_release;
    logic [IDX_W-1:0] slot_index;
  } gsa_cmd_t;

endpackage
`default_nettype wire

// File: hw/rtl/generational_slot_allocator.sv
// Top level: generational slot allocator with LIFO free stack.
// A command is taken only in the idle state; its result enters the result register from the
// finish state, which waits for that register to be free. An allocate served from the free stack
//   first passes a stack RAM read state, then a generation RAM read and write-back state.
// A two-word command queue decouples input from the sequencer and a result register.
// Synchronous reset clears counters, queue and result valid flag; the RAMs are not cleared.
`default_nettype none
module generational_slot_allocator
  import gsa_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    push,
  output logic         full,
  input  wire gsa_in_t request,
  output logic         empty,
  input  wire logic    pop,
  output gsa_out_t     result
);

  logic     cmd_valid;
  logic     cmd_take;
  gsa_cmd_t cmd;

  gsa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd      (cmd)
  );

  gsa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_take (cmd_take),
    .cmd      (cmd),
    .empty    (empty),
    .pop      (pop),
    .result   (result)
  );

endmodule
`default_nettype wire

// File: hw/rtl/gsa_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/gsa_front.sv
// Front end: accepts request words, decodes them and queues commands.
`default_nettype none
module gsa_front
  import gsa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  output logic          full,
  input  wire gsa_in_t  request,
  output logic          cmd_valid,
  input  wire logic     cmd_take,
  output gsa_cmd_t      cmd
);

  gsa_cmd_t   entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign cmd       = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr].is_release <= (request.op == OP_RELEASE);
      entries[wr_ptr].slot_index <= request.slot_index;
    end
  end

endmodule
`default_nettype wire

// File: hw/rtl/gsa_back.sv
// Back end: executes commands against the free stack and generation store.
`default_nettype none
module gsa_back
  import gsa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cmd_valid,
  output logic          cmd_take,
  input  wire gsa_cmd_t cmd,
  output logic          empty,
  input  wire logic     pop,
  output gsa_out_t      result
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_STK  = 2'd1;
  localparam logic [1:0] S_GEN  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]          state;
  logic [CNT_W-1:0]    free_count;
  logic [CNT_W-1:0]    next_fresh_slot;
  logic [IDX_W-1:0]    slot;
  gsa_out_t            pending;
  gsa_out_t            out_word;
  logic                out_valid;

  logic                stk_we;
  logic [IDX_W-1:0]    stk_waddr;
  logic                stk_re;
  logic [IDX_W-1:0]    stk_raddr;
  logic [IDX_W-1:0]    stk_rdata;
  logic                gen_we;
  logic [IDX_W-1:0]    gen_waddr;
  logic [GEN_BITS-1:0] gen_wdata;
  logic                gen_re;
  logic [GEN_BITS-1:0] gen_rdata;
  logic [GEN_BITS-1:0] gen_inc;
  logic                out_free;

  assign out_free = !out_valid || pop;
  assign empty    = !out_valid;
  assign result   = out_word;
  assign cmd_take = (state == S_IDLE) && cmd_valid;
  assign gen_inc  = gen_rdata + {{(GEN_BITS-1){1'b0}}, 1'b1};

  assign stk_re    = cmd_take && !cmd.is_release && (free_count != '0);
  assign stk_raddr = IDX_W'(free_count - {{(CNT_W-1){1'b0}}, 1'b1});
  assign stk_waddr = free_count[IDX_W-1:0];
  assign stk_we    = cmd_take && cmd.is_release
                     && ({1'b0, cmd.slot_index} < next_fresh_slot)
                     && (free_count != CNT_W'(SLOT_COUNT));
  assign gen_re    = (state == S_STK);

  always_comb begin
    gen_we    = 1'b0;
    gen_waddr = slot;
    gen_wdata = gen_inc;
    if (state == S_GEN) begin
      gen_we = 1'b1;
    end else if (cmd_take && !cmd.is_release && (free_count == '0)
                 && (next_fresh_slot != CNT_W'(SLOT_COUNT))) begin
      gen_we    = 1'b1;
      gen_waddr = next_fresh_slot[IDX_W-1:0];
      gen_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      free_count      <= '0;
      next_fresh_slot <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_take) begin
            if (stk_re) begin
              free_count <= free_count - {{(CNT_W-1){1'b0}}, 1'b1};
              state      <= S_STK;
            end else begin
              if (gen_we) begin
                next_fresh_slot <= next_fresh_slot + {{(CNT_W-1){1'b0}}, 1'b1};
              end
              if (stk_we) begin
                free_count <= free_count + {{(CNT_W-1){1'b0}}, 1'b1};
              end
              state <= S_FIN;
            end
          end
        end
        S_STK: state <= S_GEN;
        S_GEN: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_STK) begin
      slot <= stk_rdata;
    end
    if (state == S_FIN && out_free) begin
      out_word <= pending;
    end
    if (state == S_GEN) begin
      pending.handle_index      <= slot;
      pending.handle_generation <= gen_inc;
      pending.status            <= ST_OK;
    end else if (cmd_take && !stk_re) begin
      pending.handle_generation <= '0;
      if (!cmd.is_release) begin
        if (gen_we) begin
          pending.handle_index <= next_fresh_slot[IDX_W-1:0];
          pending.status       <= ST_OK;
        end else begin
          pending.handle_index <= '0;
          pending.status       <= ST_TABLE_FULL;
        end
      end else begin
        pending.handle_index <= cmd.slot_index;
        if ({1'b0, cmd.slot_index} >= next_fresh_slot) begin
          pending.status <= ST_NEVER_ALLOC;
        end else if (free_count == CNT_W'(SLOT_COUNT)) begin
          pending.status <= ST_STACK_FULL;
        end else begin
          pending.status <= ST_OK;
        end
      end
    end
  end

  gsa_ram #(
    .WIDTH(IDX_W),
    .DEPTH(SLOT_COUNT)
  ) u_free_stack (
    .clk  (clk),
    .we   (stk_we),
    .waddr(stk_waddr),
    .wdata(cmd.slot_index),
    .re   (stk_re),
    .raddr(stk_raddr),
    .rdata(stk_rdata)
  );

  gsa_ram #(
    .WIDTH(GEN_BITS),
    .DEPTH(SLOT_COUNT)
  ) u_generation_store (
    .clk  (clk),
    .we   (gen_we),
    .waddr(gen_waddr),
    .wdata(gen_wdata),
    .re   (gen_re),
    .raddr(stk_rdata),
    .rdata(gen_rdata)
  );

endmodule
`default_nettype wire
